// ----- sv/rop_pkg.sv -----
// shared types and constants of the raster-op pixel write block
`default_nettype none

package rop_pkg;

  // pipeline depth from input transfer to output register
  localparam int NSTG = 4;

  // configuration register indexes
  localparam logic [1:0] REG_FRAME_BASE = 2'd0;
  localparam logic [1:0] REG_FOUR_BYTE  = 2'd1;
  localparam logic [1:0] REG_LINE_WIDTH = 2'd2;

  localparam logic [31:0] FRAME_BASE_RST = 32'd0;
  localparam logic        FOUR_BYTE_RST  = 1'b1;
  localparam logic [15:0] LINE_WIDTH_RST = 16'd640;

  // raster-op codes
  localparam logic [7:0] OP_REPLACE  = 8'd0;
  localparam logic [7:0] OP_OR       = 8'd1;
  localparam logic [7:0] OP_AND      = 8'd2;
  localparam logic [7:0] OP_XOR      = 8'd3;
  localparam logic [7:0] OP_RED_LSB  = 8'd10;
  localparam logic [7:0] OP_GRN_LSB  = 8'd11;
  localparam logic [7:0] OP_BLU_LSB  = 8'd12;
  localparam logic [7:0] OP_MSB_ONLY = 8'd20;
  localparam logic [7:0] OP_NO_RED   = 8'd21;
  localparam logic [7:0] OP_GRAY     = 8'd22;
  localparam logic [7:0] OP_INVERT   = 8'd30;
  localparam logic [7:0] OP_BRIGHTEN = 8'd31;
  localparam logic [7:0] OP_DARKEN   = 8'd32;
  localparam logic [7:0] OP_KEEP     = 8'd40;
  localparam logic [7:0] OP_THRESH   = 8'd41;
  localparam logic [7:0] OP_POSTER   = 8'd42;

  localparam logic [7:0]  LSB_CLR_MASK = 8'hFE;
  localparam logic [7:0]  MSB_MASK     = 8'h80;
  localparam logic [7:0]  POSTER_MASK  = 8'hC0;
  localparam logic [8:0]  SAT_STEP     = 9'd50;
  localparam logic [7:0]  CH_MAX       = 8'd255;
  localparam logic [13:0] GRAY_W_RED   = 14'd30;
  localparam logic [13:0] GRAY_W_GRN   = 14'd59;
  localparam logic [13:0] GRAY_W_BLU   = 14'd11;
  // n / 100 == (n * 5243) >> 19 for every n below 43699
  localparam logic [26:0] RECIP_100    = 27'd5243;
  localparam int          RECIP_SHIFT  = 19;
  // (r + g + b) / 3 > 128 holds exactly when the sum reaches 387
  localparam logic [9:0]  THRESH_SUM   = 10'd387;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pixel_t;

  typedef struct packed {
    logic [NSTG-1:0] en;
  } stage_ctrl_t;

endpackage

`default_nettype wire

// ----- sv/rop_addr.sv -----
// address pipeline: row multiply, column add, scale by bytes per pixel
`default_nettype none

module rop_addr (
  input  wire logic                clk,
  input  wire rop_pkg::stage_ctrl_t ctrl,
  input  wire logic                four_byte_mode,
  input  wire logic [15:0]         line_width,
  input  wire logic [15:0]         pos_x,
  input  wire logic [15:0]         pos_y,
  output logic [31:0]              byte_offset
);

  logic [31:0] prod_r;
  logic [15:0] px_r;
  logic [31:0] idx_r;
  logic [31:0] scaled_r;
  logic [31:0] idx_nxt;
  logic [31:0] scaled_nxt;

  assign idx_nxt    = prod_r + {16'd0, px_r};
  // times 3 is shift plus add, wrapping at 32 bits
  assign scaled_nxt = four_byte_mode ? {idx_r[29:0], 2'b00}
                                     : {idx_r[30:0], 1'b0} + idx_r;

  always_ff @(posedge clk) begin
    if (ctrl.en[0]) begin
      prod_r <= {16'd0, pos_y} * {16'd0, line_width};
      px_r   <= pos_x;
    end
    if (ctrl.en[1]) begin
      idx_r <= idx_nxt;
    end
    if (ctrl.en[2]) begin
      scaled_r <= scaled_nxt;
    end
  end

  assign byte_offset = scaled_r;

endmodule

`default_nettype wire

// ----- sv/rop_pix.sv -----
// pixel pipeline: raster-op decode, gray weighting and final channel select
`default_nettype none

module rop_pix (
  input  wire logic                clk,
  input  wire rop_pkg::stage_ctrl_t ctrl,
  input  wire logic [31:0]         color,
  input  wire logic [7:0]          rop_code,
  input  wire rop_pkg::pixel_t     old_pix,
  output rop_pkg::pixel_t          new_pix
);

  rop_pkg::pixel_t src;
  rop_pkg::pixel_t pix1_nxt;
  rop_pkg::pixel_t pix1_r;
  rop_pkg::pixel_t pix2_r;
  rop_pkg::pixel_t pix3_r;
  rop_pkg::pixel_t pix3_nxt;
  logic            gray1_nxt;
  logic            gray1_r;
  logic            gray2_r;
  logic [13:0]     wr1_r;
  logic [13:0]     wg1_r;
  logic [13:0]     wb1_r;
  logic [26:0]     qr_full;
  logic [26:0]     qg_full;
  logic [26:0]     qb_full;
  logic [7:0]      qr2_r;
  logic [7:0]      qg2_r;
  logic [7:0]      qb2_r;
  logic [7:0]      gray_lvl;
  logic [9:0]      ch_sum;
  logic [7:0]      thr_lvl;

  assign src = color;

  function automatic logic [7:0] sat_add(input logic [7:0] c);
    logic [8:0] s;
    s = {1'b0, c} + rop_pkg::SAT_STEP;
    return s[8] ? rop_pkg::CH_MAX : s[7:0];
  endfunction

  function automatic logic [7:0] sat_sub(input logic [7:0] c);
    logic [8:0] s;
    s = {1'b0, c} - rop_pkg::SAT_STEP;
    return s[8] ? 8'd0 : s[7:0];
  endfunction

  assign ch_sum  = {2'b00, old_pix.r} + {2'b00, old_pix.g} + {2'b00, old_pix.b};
  assign thr_lvl = (ch_sum >= rop_pkg::THRESH_SUM) ? rop_pkg::CH_MAX : 8'd0;

  always_comb begin
    pix1_nxt  = old_pix;
    gray1_nxt = 1'b0;
    case (rop_code)
      rop_pkg::OP_OR: begin
        pix1_nxt.b = old_pix.b | src.b;
        pix1_nxt.g = old_pix.g | src.g;
        pix1_nxt.r = old_pix.r | src.r;
      end
      rop_pkg::OP_AND: begin
        pix1_nxt.b = old_pix.b & src.b;
        pix1_nxt.g = old_pix.g & src.g;
        pix1_nxt.r = old_pix.r & src.r;
      end
      rop_pkg::OP_XOR: begin
        pix1_nxt.b = old_pix.b ^ src.b;
        pix1_nxt.g = old_pix.g ^ src.g;
        pix1_nxt.r = old_pix.r ^ src.r;
      end
      rop_pkg::OP_RED_LSB: pix1_nxt.r = old_pix.r & rop_pkg::LSB_CLR_MASK;
      rop_pkg::OP_GRN_LSB: pix1_nxt.g = old_pix.g & rop_pkg::LSB_CLR_MASK;
      rop_pkg::OP_BLU_LSB: pix1_nxt.b = old_pix.b & rop_pkg::LSB_CLR_MASK;
      rop_pkg::OP_MSB_ONLY: begin
        pix1_nxt.b = old_pix.b & rop_pkg::MSB_MASK;
        pix1_nxt.g = old_pix.g & rop_pkg::MSB_MASK;
        pix1_nxt.r = old_pix.r & rop_pkg::MSB_MASK;
      end
      rop_pkg::OP_NO_RED: pix1_nxt.r = 8'd0;
      rop_pkg::OP_GRAY:   gray1_nxt  = 1'b1;
      rop_pkg::OP_INVERT: begin
        pix1_nxt.b = ~old_pix.b;
        pix1_nxt.g = ~old_pix.g;
        pix1_nxt.r = ~old_pix.r;
      end
      rop_pkg::OP_BRIGHTEN: begin
        pix1_nxt.b = sat_add(old_pix.b);
        pix1_nxt.g = sat_add(old_pix.g);
        pix1_nxt.r = sat_add(old_pix.r);
      end
      rop_pkg::OP_DARKEN: begin
        pix1_nxt.b = sat_sub(old_pix.b);
        pix1_nxt.g = sat_sub(old_pix.g);
        pix1_nxt.r = sat_sub(old_pix.r);
      end
      rop_pkg::OP_KEEP: pix1_nxt = old_pix;
      rop_pkg::OP_THRESH: begin
        pix1_nxt.b = thr_lvl;
        pix1_nxt.g = thr_lvl;
        pix1_nxt.r = thr_lvl;
      end
      rop_pkg::OP_POSTER: begin
        pix1_nxt.b = old_pix.b & rop_pkg::POSTER_MASK;
        pix1_nxt.g = old_pix.g & rop_pkg::POSTER_MASK;
        pix1_nxt.r = old_pix.r & rop_pkg::POSTER_MASK;
      end
      default: begin
        // replace, also taken by unknown codes
        pix1_nxt   = src;
        pix1_nxt.a = src.a + 8'd1;
      end
    endcase
  end

  // divide by 100 through a reciprocal multiply
  assign qr_full = {13'd0, wr1_r} * rop_pkg::RECIP_100;
  assign qg_full = {13'd0, wg1_r} * rop_pkg::RECIP_100;
  assign qb_full = {13'd0, wb1_r} * rop_pkg::RECIP_100;

  assign gray_lvl = qr2_r + qg2_r + qb2_r;

  always_comb begin
    pix3_nxt = pix2_r;
    if (gray2_r) begin
      pix3_nxt.b = gray_lvl;
      pix3_nxt.g = gray_lvl;
      pix3_nxt.r = gray_lvl;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[0]) begin
      pix1_r  <= pix1_nxt;
      gray1_r <= gray1_nxt;
      wr1_r   <= {6'd0, old_pix.r} * rop_pkg::GRAY_W_RED;
      wg1_r   <= {6'd0, old_pix.g} * rop_pkg::GRAY_W_GRN;
      wb1_r   <= {6'd0, old_pix.b} * rop_pkg::GRAY_W_BLU;
    end
    if (ctrl.en[1]) begin
      pix2_r  <= pix1_r;
      gray2_r <= gray1_r;
      qr2_r   <= qr_full[rop_pkg::RECIP_SHIFT +: 8];
      qg2_r   <= qg_full[rop_pkg::RECIP_SHIFT +: 8];
      qb2_r   <= qb_full[rop_pkg::RECIP_SHIFT +: 8];
    end
    if (ctrl.en[2]) begin
      pix3_r <= pix3_nxt;
    end
  end

  assign new_pix = pix3_r;

endmodule

`default_nettype wire

// ----- sv/raster_op_pixel_write_core.sv -----
// top level of the raster-op pixel write block: config, stage control, output register
//
// Takes one pixel write request per in_ transfer and returns one result per
// out_ transfer, in order. A request carries a source color, an x/y position,
// a raster-op code and the old destination pixel; the result carries the byte
// address of the pixel (frame base plus row/column offset times 3 or 4 bytes)
// and the new pixel bytes. A zero frame base returns status 1 with all other
// result fields zero.
// Four register stages: row multiply and op decode, column add and gray
// divide, byte scaling and gray select, then the output register. out_tvalid
// rises when an item reaches the output register; throughput is one item per
// cycle while out_tready stays high, and the 16x16 row multiply sets the depth
// of the first stage.
// Each stage has its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles close up while the receiver stalls and a
// full pipeline holds every item until out_tready returns.
// Reset empties the pipeline and sets frame base 0, 32 bpp and width 640.
// Configuration writes go on the cfg_ port while no item is in flight.
`default_nettype none

module raster_op_pixel_write_core (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_wr_en,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // color, pos_x, pos_y, rop_code, old_blue, old_green, old_red, old_alpha
  input  wire logic [103:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // write_address, new_blue, new_green, new_red, new_alpha
  output logic [63:0]       out_tdata,
  // status, alpha_write
  output logic [1:0]        out_tuser
);

  localparam int NSTG = rop_pkg::NSTG;

  logic [31:0]          frame_base_r;
  logic                 four_byte_r;
  logic [15:0]          line_width_r;
  logic [NSTG-1:0]      v_r;
  logic [NSTG:0]        stg_rdy;
  rop_pkg::stage_ctrl_t ctrl;
  rop_pkg::pixel_t      old_pix;
  rop_pkg::pixel_t      new_pix;
  logic [31:0]          byte_offset;
  logic [31:0]          addr_nxt;
  logic [31:0]          addr_r;
  rop_pkg::pixel_t      pix_r;
  logic                 status_r;
  logic                 alpha_wr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_base_r <= rop_pkg::FRAME_BASE_RST;
      four_byte_r  <= rop_pkg::FOUR_BYTE_RST;
      line_width_r <= rop_pkg::LINE_WIDTH_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        rop_pkg::REG_FRAME_BASE: frame_base_r <= cfg_data;
        rop_pkg::REG_FOUR_BYTE:  four_byte_r  <= cfg_data[0];
        rop_pkg::REG_LINE_WIDTH: line_width_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // a stage loads when empty or when the next one moves
  always_comb begin
    stg_rdy[NSTG] = out_tready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      stg_rdy[k] = !v_r[k] || stg_rdy[k+1];
    end
  end
  assign ctrl.en   = stg_rdy[NSTG-1:0];
  assign in_tready = stg_rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (stg_rdy[k]) begin
          v_r[k] <= (k == 0) ? in_tvalid : v_r[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  assign old_pix.b = in_tdata[79:72];
  assign old_pix.g = in_tdata[87:80];
  assign old_pix.r = in_tdata[95:88];
  assign old_pix.a = in_tdata[103:96];

  rop_addr u_addr (
    .clk            (clk),
    .ctrl           (ctrl),
    .four_byte_mode (four_byte_r),
    .line_width     (line_width_r),
    .pos_x          (in_tdata[47:32]),
    .pos_y          (in_tdata[63:48]),
    .byte_offset    (byte_offset)
  );

  rop_pix u_pix (
    .clk      (clk),
    .ctrl     (ctrl),
    .color    (in_tdata[31:0]),
    .rop_code (in_tdata[71:64]),
    .old_pix  (old_pix),
    .new_pix  (new_pix)
  );

  assign addr_nxt = byte_offset + frame_base_r;

  always_ff @(posedge clk) begin
    if (ctrl.en[NSTG-1]) begin
      if (frame_base_r == '0) begin
        status_r   <= 1'b1;
        addr_r     <= '0;
        pix_r      <= '0;
        alpha_wr_r <= 1'b0;
      end else begin
        status_r   <= 1'b0;
        addr_r     <= addr_nxt;
        pix_r.b    <= new_pix.b;
        pix_r.g    <= new_pix.g;
        pix_r.r    <= new_pix.r;
        pix_r.a    <= four_byte_r ? new_pix.a : 8'd0;
        alpha_wr_r <= four_byte_r;
      end
    end
  end

  assign out_tvalid = v_r[NSTG-1];
  assign out_tdata  = {pix_r.a, pix_r.r, pix_r.g, pix_r.b, addr_r};
  assign out_tuser  = {alpha_wr_r, status_r};

  // a full pipeline with a stalled receiver takes nothing new
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (&v_r) && !out_tready |-> !in_tready)
    else $error("input taken while pipeline full and stalled");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v_r[0])
    else $error("accepted item lost at first stage");

  a_nobuf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0 && !out_tuser[1])
    else $error("no-buffer result carries data");

  a_alpha_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tuser[1] == four_byte_r)
    else $error("alpha write flag disagrees with pixel format");

endmodule

`default_nettype wire

// ----- tb/raster_op_pixel_write_core_tb.sv -----
// self-checking stream testbench for the raster-op pixel write core
`timescale 1ns / 100ps

module raster_op_pixel_write_core_tb;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int WD_LIMIT = 2000;
  localparam int N_PHASES = 8;
  localparam int PHASE_ITEMS = 166;
  localparam int MAX_GAP = 16;

  // packed so that the last field, color, lands in the low bits of tdata
  typedef struct packed {
    logic [7:0]  old_a;
    logic [7:0]  old_r;
    logic [7:0]  old_g;
    logic [7:0]  old_b;
    logic [7:0]  op;
    logic [15:0] py;
    logic [15:0] px;
    logic [31:0] color;
  } pix_req_t;

  // matches {out_tuser, out_tdata}
  typedef struct packed {
    logic        awr;
    logic        status;
    logic [7:0]  new_a;
    logic [7:0]  new_r;
    logic [7:0]  new_g;
    logic [7:0]  new_b;
    logic [31:0] addr;
  } pix_res_t;

  typedef struct packed {
    pix_req_t    req;
    logic [31:0] base;
    logic        four;
    logic [15:0] width;
    logic        typed;
    pix_res_t    res;
  } dir_row_t;

  localparam pix_res_t NO_BUF = {1'b0, 1'b1, 32'd0, 32'd0};

  logic          clk;
  logic          rst_n;
  logic          cfg_wr_en;
  logic [1:0]    cfg_index;
  logic [31:0]   cfg_data;
  logic          in_tvalid;
  logic          in_tready;
  logic [103:0]  in_tdata;
  logic          out_tvalid;
  logic          out_tready;
  logic [63:0]   out_tdata;
  logic [1:0]    out_tuser;

  // copy of the register file as the block should hold it
  logic [31:0]   fb_base;
  logic          fb_four;
  logic [15:0]   fb_width;

  pix_res_t      pending_writes[$];
  dir_row_t      dir_tab[$];
  logic [7:0]    known_ops[16];

  int            err_cnt;
  int            n_sent;
  int            n_checked;
  int            n_nobuf;
  int            n_24bpp;
  int            n_settings;
  int            stall_left;
  int            idle_cycles;
  bit            send_burst;
  bit            recv_burst;

  raster_op_pixel_write_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic pix_res_t predict_pixel_write(input pix_req_t q);
    pix_res_t   res;
    logic [63:0] lin;
    int         ch_b, ch_g, ch_r, ch_a, gray;
    res = '0;
    if (fb_base == 32'd0) begin
      res.status = 1'b1;
      return res;
    end
    lin = (64'(q.py) * 64'(fb_width) + 64'(q.px)) * (fb_four ? 64'd4 : 64'd3)
          + 64'(fb_base);
    ch_b = q.old_b;
    ch_g = q.old_g;
    ch_r = q.old_r;
    ch_a = q.old_a;
    case (q.op)
      rop_pkg::OP_OR: begin
        ch_b = q.old_b | q.color[7:0];
        ch_g = q.old_g | q.color[15:8];
        ch_r = q.old_r | q.color[23:16];
      end
      rop_pkg::OP_AND: begin
        ch_b = q.old_b & q.color[7:0];
        ch_g = q.old_g & q.color[15:8];
        ch_r = q.old_r & q.color[23:16];
      end
      rop_pkg::OP_XOR: begin
        ch_b = q.old_b ^ q.color[7:0];
        ch_g = q.old_g ^ q.color[15:8];
        ch_r = q.old_r ^ q.color[23:16];
      end
      rop_pkg::OP_RED_LSB: ch_r = ch_r & 8'hFE;
      rop_pkg::OP_GRN_LSB: ch_g = ch_g & 8'hFE;
      rop_pkg::OP_BLU_LSB: ch_b = ch_b & 8'hFE;
      rop_pkg::OP_MSB_ONLY: begin
        ch_b = ch_b & 8'h80;
        ch_g = ch_g & 8'h80;
        ch_r = ch_r & 8'h80;
      end
      rop_pkg::OP_NO_RED: ch_r = 0;
      rop_pkg::OP_GRAY: begin
        gray = (ch_r * 30) / 100 + (ch_g * 59) / 100 + (ch_b * 11) / 100;
        ch_b = gray;
        ch_g = gray;
        ch_r = gray;
      end
      rop_pkg::OP_INVERT: begin
        ch_b = 255 - ch_b;
        ch_g = 255 - ch_g;
        ch_r = 255 - ch_r;
      end
      rop_pkg::OP_BRIGHTEN: begin
        ch_b = (ch_b + 50 > 255) ? 255 : ch_b + 50;
        ch_g = (ch_g + 50 > 255) ? 255 : ch_g + 50;
        ch_r = (ch_r + 50 > 255) ? 255 : ch_r + 50;
      end
      rop_pkg::OP_DARKEN: begin
        ch_b = (ch_b < 50) ? 0 : ch_b - 50;
        ch_g = (ch_g < 50) ? 0 : ch_g - 50;
        ch_r = (ch_r < 50) ? 0 : ch_r - 50;
      end
      rop_pkg::OP_KEEP: ;
      rop_pkg::OP_THRESH: begin
        gray = ((ch_r + ch_g + ch_b) / 3 > 128) ? 255 : 0;
        ch_b = gray;
        ch_g = gray;
        ch_r = gray;
      end
      rop_pkg::OP_POSTER: begin
        ch_b = (ch_b / 64) * 64;
        ch_g = (ch_g / 64) * 64;
        ch_r = (ch_r / 64) * 64;
      end
      // replace, and any code without a meaning of its own
      default: begin
        ch_b = q.color[7:0];
        ch_g = q.color[15:8];
        ch_r = q.color[23:16];
        ch_a = (q.color[31:24] + 1) % 256;
      end
    endcase
    res.addr  = lin[31:0];
    res.new_b = ch_b[7:0];
    res.new_g = ch_g[7:0];
    res.new_r = ch_r[7:0];
    res.new_a = fb_four ? ch_a[7:0] : 8'd0;
    res.awr   = fb_four;
    return res;
  endfunction

  function automatic pix_req_t mk_req(input logic [31:0] color, input logic [15:0] px,
                                      input logic [15:0] py, input logic [7:0] op,
                                      input logic [7:0] b, input logic [7:0] g,
                                      input logic [7:0] r, input logic [7:0] a);
    pix_req_t q;
    q.color = color;
    q.px    = px;
    q.py    = py;
    q.op    = op;
    q.old_b = b;
    q.old_g = g;
    q.old_r = r;
    q.old_a = a;
    return q;
  endfunction

  task automatic add_row(input pix_req_t q, input logic [31:0] base, input logic four,
                         input logic [15:0] width, input logic typed, input pix_res_t res);
    dir_row_t row;
    row.req   = q;
    row.base  = base;
    row.four  = four;
    row.width = width;
    row.typed = typed;
    row.res   = res;
    dir_tab.push_back(row);
  endtask

  // corner bytes hit the saturation, threshold and posterize edges
  function automatic logic [7:0] pick_byte();
    logic [7:0] v;
    v = 8'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 7))
        0: v = 8'd0;
        1: v = 8'd255;
        2: v = 8'd49;
        3: v = 8'd50;
        4: v = 8'd205;
        5: v = 8'd206;
        6: v = 8'd128;
        default: v = 8'd129;
      endcase
    end
    return v;
  endfunction

  function automatic logic [15:0] pick_pos();
    logic [15:0] v;
    case ($urandom_range(0, 3))
      0: v = 16'($urandom_range(0, 63));
      1: v = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  function automatic pix_req_t rand_req();
    pix_req_t q;
    q.color = $urandom;
    q.px    = pick_pos();
    q.py    = pick_pos();
    q.op    = ($urandom_range(0, 19) < 17) ? known_ops[$urandom_range(0, 15)]
                                           : 8'($urandom);
    q.old_b = pick_byte();
    q.old_g = pick_byte();
    q.old_r = pick_byte();
    q.old_a = pick_byte();
    return q;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      rop_pkg::REG_FRAME_BASE: fb_base = val;
      rop_pkg::REG_FOUR_BYTE:  fb_four = val[0];
      rop_pkg::REG_LINE_WIDTH: fb_width = val[15:0];
      default: ;
    endcase
  endtask

  // entered at a rising edge; returns at the edge where the transfer happens
  task automatic send_pixel(input pix_req_t q, input pix_res_t res);
    int gap;
    if (n_sent % 64 == 0)
      send_burst = ($urandom_range(0, 3) == 0);
    gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= q;
    do @(negedge clk); while (!in_tready);
    pending_writes.push_back(res);
    n_sent++;
    @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
  endtask

  // receiver: out_tready low for a drawn number of cycles before each result
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // signals are stable mid-cycle, so the upcoming edge's transfers are known here
  always @(negedge clk) begin
    pix_res_t act;
    pix_res_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      act = {out_tuser, out_tdata};
      n_checked++;
      if (act.status) n_nobuf++;
      else if (!act.awr) n_24bpp++;
      if (n_checked % 64 == 0)
        recv_burst = ($urandom_range(0, 3) == 0);
      stall_left = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (pending_writes.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("%0t: result with no pending write: %h", $realtime, act);
      end else begin
        exp_res = pending_writes.pop_front();
        if (act.status !== exp_res.status || act.addr !== exp_res.addr ||
            act.new_b !== exp_res.new_b || act.new_g !== exp_res.new_g ||
            act.new_r !== exp_res.new_r || act.new_a !== exp_res.new_a ||
            act.awr !== exp_res.awr) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("%0t: mismatch  exp st=%b addr=%h bgra=%h_%h_%h_%h aw=%b",
                     $realtime, exp_res.status, exp_res.addr, exp_res.new_b,
                     exp_res.new_g, exp_res.new_r, exp_res.new_a, exp_res.awr);
            $display("                act st=%b addr=%h bgra=%h_%h_%h_%h aw=%b",
                     act.status, act.addr, act.new_b, act.new_g, act.new_r,
                     act.new_a, act.awr);
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WD_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d writes pending",
               idle_cycles, pending_writes.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int          p;
    int          k;
    dir_row_t    row;
    pix_req_t    q;
    logic [31:0] base_v;
    logic [31:0] d;
    logic        four_v;
    logic [15:0] width_v;

    err_cnt = 0;
    n_sent = 0;
    n_checked = 0;
    n_nobuf = 0;
    n_24bpp = 0;
    n_settings = 1;
    stall_left = 0;
    idle_cycles = 0;
    send_burst = 1'b0;
    recv_burst = 1'b0;
    fb_base  = rop_pkg::FRAME_BASE_RST;
    fb_four  = rop_pkg::FOUR_BYTE_RST;
    fb_width = rop_pkg::LINE_WIDTH_RST;
    known_ops = '{rop_pkg::OP_REPLACE, rop_pkg::OP_OR, rop_pkg::OP_AND,
                  rop_pkg::OP_XOR, rop_pkg::OP_RED_LSB, rop_pkg::OP_GRN_LSB,
                  rop_pkg::OP_BLU_LSB, rop_pkg::OP_MSB_ONLY, rop_pkg::OP_NO_RED,
                  rop_pkg::OP_GRAY, rop_pkg::OP_INVERT, rop_pkg::OP_BRIGHTEN,
                  rop_pkg::OP_DARKEN, rop_pkg::OP_KEEP, rop_pkg::OP_THRESH,
                  rop_pkg::OP_POSTER};

    rst_n     <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= rop_pkg::REG_FRAME_BASE;
    cfg_data  <= 32'd0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;

    // reset values: no buffer until a base is written
    add_row(mk_req(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, rop_pkg::OP_REPLACE,
                   8'hFF, 8'hFF, 8'hFF, 8'hFF),
            32'd0, 1'b1, 16'd640, 1'b1, NO_BUF);
    add_row(mk_req(32'd0, 16'd0, 16'd0, rop_pkg::OP_POSTER, 8'd0, 8'd0, 8'd0, 8'd0),
            32'd0, 1'b1, 16'd640, 1'b1, NO_BUF);
    add_row(mk_req(32'h1234_5678, 16'd0, 16'd0, rop_pkg::OP_REPLACE,
                   8'd0, 8'd0, 8'd0, 8'd0),
            32'h0010_0000, 1'b1, 16'd640, 1'b1,
            {1'b1, 1'b0, 8'h13, 8'h34, 8'h56, 8'h78, 32'h0010_0000});
    // alpha + 1 wraps to zero
    add_row(mk_req(32'hFF00_0000, 16'd1, 16'd0, rop_pkg::OP_REPLACE,
                   8'h11, 8'h22, 8'h33, 8'h44),
            32'h0010_0000, 1'b1, 16'd640, 1'b1,
            {1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0010_0004});
    add_row(mk_req(32'h0F0F_0F0F, 16'd7, 16'd3, rop_pkg::OP_OR, 8'hF0, 8'hA5, 8'h00, 8'h5A),
            32'h0010_0000, 1'b1, 16'd640, 1'b0, '0);
    add_row(mk_req(32'h0F3C_A5FF, 16'd8, 16'd3, rop_pkg::OP_AND, 8'hF0, 8'hFF, 8'h3C, 8'h01),
            32'h0010_0000, 1'b1, 16'd640, 1'b0, '0);
    add_row(mk_req(32'hFFFF_FFFF, 16'd9, 16'd3, rop_pkg::OP_XOR, 8'hF0, 8'h0F, 8'h00, 8'hFF),
            32'h0010_0000, 1'b1, 16'd640, 1'b0, '0);
    add_row(mk_req(32'h0, 16'd10, 16'd3, rop_pkg::OP_RED_LSB, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
            32'h0010_0000, 1'b1, 16'd640, 1'b0, '0);
    add_row(mk_req(32'h0, 16'd11, 16'd3, rop_pkg::OP_GRN_LSB, 8'hFF, 8'hFF, 8'hFF, 8'h00),
            32'h0010_0000, 1'b1, 16'd640, 1'b0, '0);
    add_row(mk_req(32'h0, 16'd12, 16'd3, rop_pkg::OP_BLU_LSB, 8'hFF, 8'h01, 8'h81, 8'h80),
            32'h0010_0000, 1'b1, 16'd640, 1'b0, '0);
    add_row(mk_req(32'h0, 16'd13, 16'd3, rop_pkg::OP_MSB_ONLY, 8'hFF, 8'h7F, 8'h80, 8'h33),
            32'h0010_0000, 1'b1, 16'd640, 1'b0, '0);
    add_row(mk_req(32'hFFFF_FFFF, 16'd14, 16'd3, rop_pkg::OP_NO_RED,
                   8'h12, 8'h34, 8'hFF, 8'h56),
            32'h0010_0000, 1'b1, 16'd640, 1'b0, '0);
    add_row(mk_req(32'h0, 16'd15, 16'd3, rop_pkg::OP_GRAY, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
            32'h0010_0000, 1'b1, 16'd640, 1'b0, '0);
    add_row(mk_req(32'h0, 16'd16, 16'd3, rop_pkg::OP_INVERT, 8'h00, 8'h5A, 8'hFF, 8'h77),
            32'h0010_0000, 1'b1, 16'd640, 1'b0, '0);
    // saturation edges on both sides
    add_row(mk_req(32'h0, 16'd17, 16'd3, rop_pkg::OP_BRIGHTEN, 8'd205, 8'd206, 8'd0, 8'd9),
            32'h0010_0000, 1'b1, 16'd640, 1'b0, '0);
    add_row(mk_req(32'h0, 16'd18, 16'd3, rop_pkg::OP_DARKEN, 8'd49, 8'd50, 8'd255, 8'd9),
            32'h0010_0000, 1'b1, 16'd640, 1'b0, '0);
    add_row(mk_req(32'hDEAD_BEEF, 16'd19, 16'd3, rop_pkg::OP_KEEP,
                   8'h01, 8'h02, 8'h03, 8'hC4),
            32'h0010_0000, 1'b1, 16'd640, 1'b0, '0);
    // threshold just above and just at the boundary
    add_row(mk_req(32'h0, 16'd20, 16'd3, rop_pkg::OP_THRESH, 8'd129, 8'd129, 8'd129, 8'd0),
            32'h0010_0000, 1'b1, 16'd640, 1'b0, '0);
    add_row(mk_req(32'h0, 16'd21, 16'd3, rop_pkg::OP_THRESH, 8'd128, 8'd129, 8'd129, 8'd0),
            32'h0010_0000, 1'b1, 16'd640, 1'b0, '0);
    add_row(mk_req(32'h0, 16'd22, 16'd3, rop_pkg::OP_POSTER, 8'd63, 8'd64, 8'd255, 8'd1),
            32'h0010_0000, 1'b1, 16'd640, 1'b0, '0);
    // undefined op codes fall back to replace
    add_row(mk_req(32'hA1B2_C3D4, 16'd23, 16'd3, 8'd255, 8'h00, 8'h00, 8'h00, 8'h00),
            32'h0010_0000, 1'b1, 16'd640, 1'b0, '0);
    add_row(mk_req(32'h5566_7788, 16'd24, 16'd3, 8'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
            32'h0010_0000, 1'b1, 16'd640, 1'b0, '0);
    // 24 bpp: alpha neither read nor written
    add_row(mk_req(32'h80AA_BBCC, 16'd2, 16'd1, rop_pkg::OP_REPLACE,
                   8'h00, 8'h00, 8'h00, 8'h55),
            32'h0010_0000, 1'b0, 16'd640, 1'b1,
            {1'b0, 1'b0, 8'h00, 8'hAA, 8'hBB, 8'hCC, 32'h0010_0786});
    // address wraps past 2^32
    add_row(mk_req(32'h0102_0304, 16'hFFFF, 16'hFFFF, rop_pkg::OP_INVERT,
                   8'h10, 8'h20, 8'h30, 8'h40),
            32'hFFFF_FFFF, 1'b1, 16'hFFFF, 1'b0, '0);
    add_row(mk_req(32'h0102_0304, 16'd5, 16'd1000, rop_pkg::OP_XOR,
                   8'h10, 8'h20, 8'h30, 8'h40),
            32'd1, 1'b1, 16'd0, 1'b0, '0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < dir_tab.size(); k++) begin
      row = dir_tab[k];
      if (row.base != fb_base || row.four != fb_four || row.width != fb_width) begin
        drain();
        write_reg(rop_pkg::REG_FRAME_BASE, row.base);
        write_reg(rop_pkg::REG_FOUR_BYTE, {31'd0, row.four});
        write_reg(rop_pkg::REG_LINE_WIDTH, {16'd0, row.width});
        n_settings++;
      end
      send_pixel(row.req, row.typed ? row.res : predict_pixel_write(row.req));
    end

    for (p = 0; p < N_PHASES; p++) begin
      case (p)
        0: begin
          base_v = 32'hFFFF_FFFF;
          four_v = 1'b0;
          width_v = 16'hFFFF;
        end
        1: begin
          base_v = 32'd1;
          four_v = 1'b1;
          width_v = 16'd0;
        end
        2: begin
          base_v = 32'd0;
          four_v = 1'b0;
          width_v = 16'($urandom);
        end
        default: begin
          base_v = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF00 : $urandom;
          four_v = 1'($urandom);
          width_v = ($urandom_range(0, 2) == 0) ? 16'd640 : 16'($urandom);
        end
      endcase
      drain();
      write_reg(rop_pkg::REG_FRAME_BASE, base_v);
      // upper bits of the narrow registers carry junk that must be dropped
      d = $urandom;
      d[0] = four_v;
      write_reg(rop_pkg::REG_FOUR_BYTE, d);
      d = $urandom;
      d[15:0] = width_v;
      write_reg(rop_pkg::REG_LINE_WIDTH, d);
      write_reg(REG_UNUSED, $urandom);
      n_settings++;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        q = rand_req();
        send_pixel(q, predict_pixel_write(q));
      end
    end

    drain();
    repeat (2 * rop_pkg::NSTG + 4) @(posedge clk);
    err_cnt += pending_writes.size();

    $display("sent %0d pixel writes over %0d register settings, %0d results checked",
             n_sent, n_settings, n_checked);
    $display("no-buffer results %0d, 24 bpp results %0d, errors %0d",
             n_nobuf, n_24bpp, err_cnt);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
